// ===== rtl/ccr_pkg.sv =====
// Shared types, widths and codes for the column composite reduction block.
// Used by the arithmetic unit and by the top level; depends on nothing.
package ccr_pkg;

    // Field and accumulator widths.
    localparam int REFL_W = 12;
    localparam int SUM_W = 17;
    localparam int CNT_W = 5;
    localparam int ALU_W = 19;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int TDATA_W = 16;

    // Valid samples beyond this count no longer enter sum and count.
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 5'd31;

    // Composite modes.
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

    typedef logic [ALU_W-1:0] alu_word_t;

    // Operand request to the shared add/subtract unit.
    typedef struct packed {
        alu_word_t a;
        alu_word_t b;
        logic      sub;
    } alu_req_t;

    // Sign extension of a reflectivity value to the unit width.
    function automatic alu_word_t sext_refl(input logic [REFL_W-1:0] x);
        return {{(ALU_W-REFL_W){x[REFL_W-1]}}, x};
    endfunction

    // Sign extension of a sum-wide value to the unit width.
    function automatic alu_word_t sext_sum(input logic [SUM_W-1:0] x);
        return {{(ALU_W-SUM_W){x[SUM_W-1]}}, x};
    endfunction

endpackage

// ===== rtl/column_composite_reduce_top.sv =====
// Column composite reduction: one composite per column of reflectivity samples.
// Each sample passes the sum state and, when valid, the qualify and best states; a new
// sample is taken only in idle. The last sample then runs the finish states of its mode, in mean mode
// the 17-step restoring divide on the shared unit, and any wait for the output register.
// Reset (aresetn, synchronous, active low) clears the column state and the output valid,
// and sets mode to maximum and threshold to zero.
module column_composite_reduce_top import ccr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [11:0] refl
    input  logic                 s_axis_tuser,   // [0] sample_valid
    input  logic                 s_axis_tlast,   // last_in_column
    // Result channel.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [11:0] composite
    output logic                 m_axis_tuser,   // [0] composite_valid
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REFL_W-1:0]    cfg_data
);

    // Sequencer codes.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_QUAL = 4'd2;
    localparam logic [3:0] S_BEST = 4'd3;
    localparam logic [3:0] S_FIN  = 4'd4;
    localparam logic [3:0] S_MAXT = 4'd5;
    localparam logic [3:0] S_MCMP = 4'd6;
    localparam logic [3:0] S_ABS  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_NEG  = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic [3:0]              state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg;
    logic signed [REFL_W-1:0] thr_reg;

    // Sample being worked on.
    logic [REFL_W-1:0]       refl_reg;
    logic                    smp_valid_reg;
    logic                    last_reg;

    // Column state.
    logic [REFL_W-1:0]       best_reg;
    logic                    found_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    qual_reg;

    // Divide and result registers.
    logic [SUM_W-1:0]        prod_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [REFL_W-1:0]       res_reg;
    logic                    res_ok_reg;

    logic [TDATA_W-1:0]      m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    m_tvalid_reg;

    alu_req_t                alu_req;
    alu_word_t               alu_res;
    logic                    alu_neg;
    logic                    alu_zero;
    logic                    sum_neg;
    logic                    out_load;
    logic signed [REFL_W+CNT_W:0] mult;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    assign alu_neg  = alu_res[ALU_W-1];
    assign alu_zero = (alu_res == '0);
    assign sum_neg  = sum_reg[SUM_W-1];
    assign out_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_axis_tready);
    assign mult     = thr_reg * $signed({1'b0, cnt_reg});

    ccr_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // Operand selection for the shared unit, one operation per state.
    always_comb begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b1;
        unique case (state_reg)
            S_SUM: begin
                alu_req.a   = sext_sum(sum_reg);
                alu_req.b   = sext_refl(refl_reg);
                alu_req.sub = 1'b0;
            end
            S_QUAL: begin
                alu_req.a = sext_refl(thr_reg);
                alu_req.b = sext_refl(refl_reg);
            end
            S_BEST: begin
                alu_req.a = sext_refl(refl_reg);
                alu_req.b = sext_refl(best_reg);
            end
            S_MAXT: begin
                alu_req.a = sext_refl(best_reg);
                alu_req.b = sext_refl(thr_reg);
            end
            S_MCMP: begin
                alu_req.a = sext_sum(sum_reg);
                alu_req.b = sext_sum(prod_reg);
            end
            S_ABS: begin
                alu_req.b = sext_sum(sum_reg);
            end
            S_DIV: begin
                alu_req.a = {{(ALU_W-CNT_W-1){1'b0}}, rem_reg, quo_reg[SUM_W-1]};
                alu_req.b = {{(ALU_W-CNT_W){1'b0}}, cnt_reg};
            end
            S_NEG: begin
                alu_req.b = {{(ALU_W-SUM_W){1'b0}}, quo_reg};
            end
            default: begin
                alu_req.sub = 1'b0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_axis_tvalid) state_next = S_SUM;
            S_SUM: begin
                if (smp_valid_reg) state_next = S_QUAL;
                else if (last_reg) state_next = S_FIN;
                else               state_next = S_IDLE;
            end
            S_QUAL: state_next = S_BEST;
            S_BEST: state_next = last_reg ? S_FIN : S_IDLE;
            S_FIN: begin
                case (mode_reg)
                    MODE_MEAN: state_next = (cnt_reg == '0) ? S_EMIT : S_MCMP;
                    MODE_MIN:  state_next = S_EMIT;
                    default:   state_next = S_MAXT;
                endcase
            end
            S_MAXT: state_next = S_EMIT;
            S_MCMP: state_next = alu_neg ? S_EMIT : S_ABS;
            S_ABS:  state_next = S_DIV;
            S_DIV:  if (step_reg == LAST_STEP) state_next = S_NEG;
            S_NEG:  state_next = S_EMIT;
            S_EMIT: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer, configuration and column state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= MODE_MAX;
            thr_reg      <= '0;
            best_reg     <= '0;
            found_reg    <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Register writes.
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MODE:      mode_reg <= cfg_data[MODE_W-1:0];
                    REG_THRESHOLD: thr_reg  <= cfg_data;
                    default:       ;
                endcase
            end

            // Running sum and count of valid samples.
            if (state_reg == S_SUM && smp_valid_reg && cnt_reg != COUNT_LIMIT) begin
                sum_reg <= alu_res[SUM_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
            end

            // Best value: largest in max mode, smallest qualifying in min mode.
            if (state_reg == S_BEST) begin
                case (mode_reg)
                    MODE_MIN: begin
                        if (qual_reg && (!found_reg || alu_neg)) begin
                            best_reg  <= refl_reg;
                            found_reg <= 1'b1;
                        end
                    end
                    MODE_MEAN: ;
                    default: begin
                        if (!found_reg || (!alu_neg && !alu_zero)) begin
                            best_reg  <= refl_reg;
                            found_reg <= 1'b1;
                        end
                    end
                endcase
            end

            // Output register takes the result and the column starts over.
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                best_reg     <= '0;
                found_reg    <= 1'b0;
                sum_reg      <= '0;
                cnt_reg      <= '0;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: captured sample, compare flag, divider and result.
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            refl_reg      <= s_axis_tdata[REFL_W-1:0];
            smp_valid_reg <= s_axis_tuser;
            last_reg      <= s_axis_tlast;
        end

        if (state_reg == S_QUAL) begin
            qual_reg <= alu_neg;
        end

        unique case (state_reg)
            S_FIN: begin
                prod_reg   <= mult[SUM_W-1:0];
                res_ok_reg <= (mode_reg == MODE_MIN) && found_reg;
                res_reg    <= ((mode_reg == MODE_MIN) && found_reg) ? best_reg : '0;
            end
            S_MAXT: begin
                res_ok_reg <= found_reg && !alu_neg;
                res_reg    <= (found_reg && !alu_neg) ? best_reg : '0;
            end
            S_ABS: begin
                quo_reg  <= sum_neg ? alu_res[SUM_W-1:0] : sum_reg;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            S_DIV: begin
                // One restoring step: keep the trial remainder when it is not negative.
                if (!alu_neg) begin
                    rem_reg <= alu_res[CNT_W-1:0];
                    quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[CNT_W-2:0], quo_reg[SUM_W-1]};
                    quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_reg <= step_reg + 1'b1;
            end
            S_NEG: begin
                res_ok_reg <= 1'b1;
                res_reg    <= sum_neg ? alu_res[REFL_W-1:0] : quo_reg[REFL_W-1:0];
            end
            default: ;
        endcase

        if (out_load) begin
            m_tdata_reg <= {{(TDATA_W-REFL_W){1'b0}}, res_reg};
            m_tuser_reg <= res_ok_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // The divider remainder stays below the divisor.
    a_rem_below_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < cnt_reg))
        else $error("divider remainder not below count");

    // A result with no value carries a zero composite.
    a_no_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("composite not zero for missing value");

    // Handing a result to the output register starts a clean column.
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_axis_tvalid && cnt_reg == '0 && !found_reg && sum_reg == '0))
        else $error("column state not cleared after result");
`endif

endmodule

// ===== rtl/ccr_alu.sv =====
// Shared add/subtract unit of the column composite reduction block.
// Depends on ccr_pkg for the operand width and the request struct.
module ccr_alu import ccr_pkg::*; (
    input  alu_req_t  req,
    output alu_word_t res
);

    // Two's complement add, or subtract through inversion and carry in.
    assign res = req.a + (req.sub ? ~req.b : req.b) + {{(ALU_W-1){1'b0}}, req.sub};

endmodule

// ===== sim/column_composite_reduce_checker.sv =====
// Checker for the column composite reduction block: predicts one composite per column.
// It watches the sample, result and register channels and counts mismatches.
// It depends on ccr_pkg for widths, mode codes and register indexes.
`timescale 1ns / 100ps

module column_composite_reduce_checker import ccr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [11:0] refl
    input  logic                 s_axis_tuser,   // [0] sample_valid
    input  logic                 s_axis_tlast,   // last_in_column
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [TDATA_W-1:0]   m_axis_tdata,   // [11:0] composite
    input  logic                 m_axis_tuser,   // [0] composite_valid
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REFL_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending_results
);

    typedef struct {
        logic signed [REFL_W-1:0] composite;
        logic                     composite_valid;
    } composite_t;

    // Composites still owed by the block, oldest first.
    composite_t composite_q[$];

    // Register copies and the running state of the open column.
    logic [MODE_W-1:0]        cur_mode;
    logic signed [REFL_W-1:0] cur_thr;
    logic signed [REFL_W-1:0] col_best;
    logic                     col_found;
    logic signed [SUM_W-1:0]  col_sum;
    logic [CNT_W-1:0]         col_count;
    int                       errors = 0;

    task automatic clear_column();
        col_best = '0;
        col_found = 1'b0;
        col_sum = '0;
        col_count = '0;
    endtask

    // Fold one sample into the column and, on the last one, queue the composite.
    task automatic fold_sample(input logic signed [REFL_W-1:0] refl, input logic present,
                               input logic is_last);
        composite_t res;
        int total;
        int n;
        int thr_i;
        if (present) begin
            // Sum and count stop growing once the count saturates.
            if (col_count != COUNT_LIMIT) begin
                col_sum = col_sum + refl;
                col_count = col_count + 1'b1;
            end
            if (cur_mode == MODE_MIN) begin
                if (refl > cur_thr && (!col_found || refl < col_best)) begin
                    col_best = refl;
                    col_found = 1'b1;
                end
            end else if (cur_mode != MODE_MEAN) begin
                if (!col_found || refl > col_best) begin
                    col_best = refl;
                    col_found = 1'b1;
                end
            end
        end
        if (is_last) begin
            res.composite = '0;
            res.composite_valid = 1'b0;
            total = col_sum;
            n = col_count;
            thr_i = cur_thr;
            case (cur_mode)
                MODE_MEAN: begin
                    // The exact mean is compared, the truncated quotient is reported.
                    if (n > 0 && total >= thr_i * n) begin
                        res.composite = REFL_W'(total / n);
                        res.composite_valid = 1'b1;
                    end
                end
                MODE_MIN: begin
                    if (col_found) begin
                        res.composite = col_best;
                        res.composite_valid = 1'b1;
                    end
                end
                default: begin
                    // The spare mode code falls back to the column maximum.
                    if (col_found && col_best >= cur_thr) begin
                        res.composite = col_best;
                        res.composite_valid = 1'b1;
                    end
                end
            endcase
            composite_q.push_back(res);
            clear_column();
        end
    endtask

    // Track every beat and compare each result against the oldest prediction.
    always @(posedge aclk) begin
        composite_t want;
        logic signed [REFL_W-1:0] got_value;
        if (!aresetn) begin
            cur_mode = MODE_MAX;
            cur_thr = '0;
            clear_column();
            composite_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MODE) begin
                    cur_mode = cfg_data[MODE_W-1:0];
                end else if (cfg_index == REG_THRESHOLD) begin
                    cur_thr = cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                fold_sample(s_axis_tdata[REFL_W-1:0], s_axis_tuser, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_value = m_axis_tdata[REFL_W-1:0];
                if (composite_q.size() == 0) begin
                    $error("unexpected result beat: composite %0d, composite_valid %0b",
                           got_value, m_axis_tuser);
                    errors++;
                end else begin
                    want = composite_q.pop_front();
                    if (got_value !== want.composite) begin
                        $error("composite: expected %0d, actual %0d", want.composite, got_value);
                        errors++;
                    end
                    if (m_axis_tuser !== want.composite_valid) begin
                        $error("composite_valid: expected %0b, actual %0b",
                               want.composite_valid, m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
        fail_count <= errors;
        pending_results <= composite_q.size();
    end

endmodule

// ===== sim/column_composite_reduce_top_test.sv =====
// Top of the column composite reduction test: clock, reset, sample and register stimulus.
// Instantiates the block and the checker beside it; depends on ccr_pkg.
`timescale 1ns / 100ps

module column_composite_reduce_top_test;
    import ccr_pkg::*;

    // Mode code that the block leaves unused; it must behave as the maximum.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int IDLE_PCT = 32;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASES = 8;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;   // [11:0] refl
    logic                 s_axis_tuser = 1'b0; // [0] sample_valid
    logic                 s_axis_tlast = 1'b0; // last_in_column
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;        // [11:0] composite
    logic                 m_axis_tuser;        // [0] composite_valid
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REFL_W-1:0]    cfg_data = '0;

    int   fail_count;
    int   pending_results;
    int   stall_cycles = 0;
    int   hold_left = 0;
    logic hold_request = 1'b0;
    logic hold_served = 1'b0;
    logic sink_steady = 1'b0;
    bit   sender_gaps = 1'b1;

    always #5 aclk = ~aclk;

    column_composite_reduce_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    column_composite_reduce_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Result receiver: random backpressure, a steady stretch and one long hold-off.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_left <= HOLD_CYCLES;
            hold_served <= 1'b1;
            m_axis_tready <= 1'b0;
        end else if (sink_steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: too many cycles without any accepted beat ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("column_composite_reduce_top test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one sample beat, with random gaps in front when enabled.
    task automatic send_sample(input int refl, input logic present, input logic is_last);
        while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(TDATA_W-REFL_W){1'b0}}, refl[REFL_W-1:0]};
        s_axis_tuser <= present;
        s_axis_tlast <= is_last;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Stop offering samples, wait for every owed composite, then let the block go quiet.
    // The owed count is registered in the checker, so the task waits for an edge first.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[REFL_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random sample value: extremes, values around the threshold, or anything.
    function automatic int pick_refl(input int thr);
        int v;
        case ($urandom_range(9))
            0: v = -2048;
            1: v = 2047;
            2, 3: begin
                v = thr + int'($urandom_range(6)) - 3;
                if (v > 2047) v = 2047;
                if (v < -2048) v = -2048;
            end
            default: v = int'($urandom_range(4095)) - 2048;
        endcase
        return v;
    endfunction

    initial begin
        int phase;
        int thr;
        int sent;
        int len;
        int k;
        int valid_pct;
        logic [MODE_W-1:0] mode_pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Maximum with the lowest threshold: extremes, a lone missing sample, a lone minimum.
        write_reg(REG_MODE, MODE_MAX);
        write_reg(REG_THRESHOLD, -2048);
        send_sample(2047, 1'b1, 1'b0);
        send_sample(-2048, 1'b1, 1'b0);
        send_sample(5, 1'b1, 1'b1);
        send_sample(-1, 1'b0, 1'b1);
        send_sample(-2048, 1'b1, 1'b1);
        settle();

        // Maximum with the highest threshold: below it gives no value, equal passes.
        write_reg(REG_THRESHOLD, 2047);
        send_sample(2046, 1'b1, 1'b0);
        send_sample(100, 1'b1, 1'b0);
        send_sample(2047, 1'b0, 1'b1);
        send_sample(2047, 1'b1, 1'b1);
        settle();

        // Mean: negative quotient truncates toward zero, empty column gives no value.
        write_reg(REG_MODE, MODE_MEAN);
        write_reg(REG_THRESHOLD, -2048);
        send_sample(-5, 1'b1, 1'b0);
        send_sample(-2, 1'b1, 1'b1);
        send_sample(-2048, 1'b1, 1'b0);
        send_sample(-2048, 1'b1, 1'b1);
        send_sample(3, 1'b0, 1'b1);
        settle();
        write_reg(REG_THRESHOLD, 0);
        send_sample(2047, 1'b1, 1'b0);
        send_sample(2047, 1'b1, 1'b0);
        send_sample(2046, 1'b1, 1'b1);
        send_sample(1, 1'b1, 1'b0);
        send_sample(-2, 1'b1, 1'b1);
        settle();

        // Minimum strictly above the threshold; a sample equal to it does not count.
        write_reg(REG_MODE, MODE_MIN);
        write_reg(REG_THRESHOLD, 10);
        send_sample(10, 1'b1, 1'b0);
        send_sample(11, 1'b1, 1'b0);
        send_sample(-2048, 1'b1, 1'b1);
        send_sample(5, 1'b1, 1'b0);
        send_sample(10, 1'b1, 1'b1);
        settle();

        // The spare mode code acts as the maximum.
        write_reg(REG_MODE, MODE_SPARE);
        write_reg(REG_THRESHOLD, -100);
        send_sample(-50, 1'b1, 1'b0);
        send_sample(30, 1'b1, 1'b1);
        settle();

        // Registers change in the middle of a column: the best value mixes both rules.
        write_reg(REG_MODE, MODE_MAX);
        write_reg(REG_THRESHOLD, 0);
        send_sample(100, 1'b1, 1'b0);
        send_sample(200, 1'b1, 1'b0);
        settle();
        write_reg(REG_MODE, MODE_MIN);
        write_reg(REG_THRESHOLD, 150);
        send_sample(180, 1'b1, 1'b0);
        send_sample(50, 1'b1, 1'b1);

        // Random columns, one register setting per phase.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase % 4)
                0: mode_pick = MODE_MAX;
                1: mode_pick = MODE_MEAN;
                2: mode_pick = MODE_MIN;
                default: mode_pick = MODE_SPARE;
            endcase
            case (phase)
                1: thr = -2048;
                3: thr = 2047;
                7: thr = 0;
                2, 4, 6: thr = int'($urandom_range(600)) - 300;
                default: thr = int'($urandom_range(4095)) - 2048;
            endcase
            write_reg(REG_MODE, mode_pick);
            write_reg(REG_THRESHOLD, thr);

            // Phase 2 runs without idling; phase 5 fills the block behind a held receiver.
            sender_gaps = (phase != 2 && phase != 5);
            sink_steady <= (phase == 2);
            if (phase == 5) begin
                hold_request <= 1'b1;
            end

            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                // Mostly ordinary columns; now and then one long enough to saturate the count.
                if ($urandom_range(11) == 0) begin
                    len = $urandom_range(40, 32);
                    valid_pct = 97;
                end else begin
                    len = $urandom_range(16, 1);
                    valid_pct = 80;
                end
                for (k = 0; k < len; k++) begin
                    send_sample(pick_refl(thr), $urandom_range(99) < valid_pct, k == len - 1);
                end
                sent += len;
            end
        end

        settle();
        if (fail_count == 0 && pending_results == 0) begin
            $display("column_composite_reduce_top test passed");
        end else begin
            $display("column_composite_reduce_top test failed");
        end
        $finish;
    end

endmodule
